/* hdl/scissor_rect_checker_unit_defines.svh */
// Assertion helpers for the scissor rectangle checker
`ifndef SCISSOR_RECT_CHECKER_UNIT_DEFINES_SVH
`define SCISSOR_RECT_CHECKER_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define SCRC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scrc check failed");

// Check that a condition implies another in the next cycle
`define SCRC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scrc check failed");

`endif

/* hdl/scrc_pkg.sv */
package scrc_pkg;

  localparam int DIM_BITS    = 14;
  localparam int COUNT_BITS  = 16;
  localparam int COORD_W     = 20;
  localparam int SCALE_W     = 16;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = DIFF_W + SCALE_W;
  localparam int FRAC_BITS   = 16;
  localparam int FIX_W       = DIM_BITS + FRAC_BITS;
  localparam int BADCNT_W    = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ATT_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ATT_HEIGHT = 3'd7;

  localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd4096;

  typedef struct packed {
    logic signed [COORD_W-1:0] offset_x;
    logic signed [COORD_W-1:0] offset_y;
    logic [SCALE_W-1:0]        scale_x;
    logic [SCALE_W-1:0]        scale_y;
    logic [DIM_BITS-1:0]       fb_width;
    logic [DIM_BITS-1:0]       fb_height;
    logic [DIM_BITS-1:0]       att_width;
    logic [DIM_BITS-1:0]       att_height;
  } cfg_t;

  // Classified command with exact framebuffer-space edges
  typedef struct packed {
    logic                     frame_start;
    logic                     skip;
    logic signed [PROD_W-1:0] mnx;
    logic signed [PROD_W-1:0] mny;
    logic signed [PROD_W-1:0] mxx;
    logic signed [PROD_W-1:0] mxy;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic front_vld;
    logic q_full;
    logic q_empty;
  } status_t;

  // Subtract origin and scale to 2^-16 pixel units
  function automatic logic signed [PROD_W-1:0] scale_coord(
    input logic signed [COORD_W-1:0] clip,
    input logic signed [COORD_W-1:0] off,
    input logic [SCALE_W-1:0]        scale
  );
    logic signed [DIFF_W-1:0] d;
    logic signed [PROD_W:0]   p;
    d = {clip[COORD_W-1], clip} - {off[COORD_W-1], off};
    p = d * $signed({1'b0, scale});
    return p[PROD_W-1:0];
  endfunction

endpackage

/* hdl/scissor_rect_checker_unit.sv */
// Channel   | Handshake            | Payload
// ----------+----------------------+------------------------------------------------
// in_       | in_valid / in_stall  | frame_start, is_callback, no_elements, clip edges
// out_      | out_valid / out_stall| skipped, rect x/y/w/h, degenerate, exceeds, count
// cfg_      | cfg_valid / cfg_ready| cfg_index (register), cfg_data
//
// One item per cycle sustained while out_stall is low. An accepted item passes the
// front scaling register, queue, clamp stage and flag/counter output register in order.
// The per-frame bad counter sits in the output stage and updates as each item
// leaves the clamp stage. Synchronous active-low reset clears all valid state,
// the counter and the configuration registers to their reset values. A stall on
// the output backs up through the clamp stage into the two-entry queue, and in_stall
// rises only once the queue is full with the front register holding an item.
`include "scissor_rect_checker_unit_defines.svh"

module scissor_rect_checker_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scrc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_frame_start,
  input  logic                                in_is_callback,
  input  logic                                in_no_elements,
  input  logic signed [scrc_pkg::COORD_W-1:0] in_clip_min_x,
  input  logic signed [scrc_pkg::COORD_W-1:0] in_clip_min_y,
  input  logic signed [scrc_pkg::COORD_W-1:0] in_clip_max_x,
  input  logic signed [scrc_pkg::COORD_W-1:0] in_clip_max_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_skipped,
  output logic [scrc_pkg::DIM_BITS-1:0]       out_rect_x,
  output logic [scrc_pkg::DIM_BITS-1:0]       out_rect_y,
  output logic [scrc_pkg::DIM_BITS-1:0]       out_rect_w,
  output logic [scrc_pkg::DIM_BITS-1:0]       out_rect_h,
  output logic                                out_degenerate,
  output logic                                out_exceeds,
  output logic [scrc_pkg::BADCNT_W-1:0]       out_bad_count
);
  import scrc_pkg::*;

  cfg_t    cfg_r;
  cmd_t    push_cmd, pop_cmd;
  logic    push, pop;
  q_stat_t q_stat;
  status_t stat;
  logic    front_vld;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_x   <= '0;
      cfg_r.offset_y   <= '0;
      cfg_r.scale_x    <= SCALE_ONE;
      cfg_r.scale_y    <= SCALE_ONE;
      cfg_r.fb_width   <= '0;
      cfg_r.fb_height  <= '0;
      cfg_r.att_width  <= '0;
      cfg_r.att_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OFFSET_X:   cfg_r.offset_x   <= cfg_data[COORD_W-1:0];
        REG_OFFSET_Y:   cfg_r.offset_y   <= cfg_data[COORD_W-1:0];
        REG_SCALE_X:    cfg_r.scale_x    <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Y:    cfg_r.scale_y    <= cfg_data[SCALE_W-1:0];
        REG_FB_WIDTH:   cfg_r.fb_width   <= cfg_data[DIM_BITS-1:0];
        REG_FB_HEIGHT:  cfg_r.fb_height  <= cfg_data[DIM_BITS-1:0];
        REG_ATT_WIDTH:  cfg_r.att_width  <= cfg_data[DIM_BITS-1:0];
        REG_ATT_HEIGHT: cfg_r.att_height <= cfg_data[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  scrc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_frame_start (in_frame_start),
    .in_is_callback (in_is_callback),
    .in_no_elements (in_no_elements),
    .in_clip_min_x  (in_clip_min_x),
    .in_clip_min_y  (in_clip_min_y),
    .in_clip_max_x  (in_clip_max_x),
    .in_clip_max_y  (in_clip_max_y),
    .push           (push),
    .push_cmd       (push_cmd),
    .q_full         (q_stat.full),
    .front_vld      (front_vld)
  );

  scrc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .stat     (q_stat)
  );

  scrc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (q_stat.empty),
    .pop_cmd        (pop_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_skipped    (out_skipped),
    .out_rect_x     (out_rect_x),
    .out_rect_y     (out_rect_y),
    .out_rect_w     (out_rect_w),
    .out_rect_h     (out_rect_h),
    .out_degenerate (out_degenerate),
    .out_exceeds    (out_exceeds),
    .out_bad_count  (out_bad_count)
  );

  assign stat.front_vld = front_vld;
  assign stat.q_full    = q_stat.full;
  assign stat.q_empty   = q_stat.empty;

  // Queue cannot be full and empty at once
  `SCRC_ASSERT_IMP(a_queue_state, 1'b1, !(stat.q_full && stat.q_empty))
  // An accepted item lands in the front register
  `SCRC_ASSERT_NXT(a_front_load, in_valid && !in_stall, stat.front_vld)
  // A skipped result carries no rectangle and no flags
  `SCRC_ASSERT_IMP(a_skip_zero, out_valid && out_skipped,
                   out_rect_x == '0 && out_rect_w == '0 && !out_degenerate && !out_exceeds)

endmodule

/* hdl/scrc_front.sv */
module scrc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  scrc_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_frame_start,
  input  logic                              in_is_callback,
  input  logic                              in_no_elements,
  input  logic signed [scrc_pkg::COORD_W-1:0] in_clip_min_x,
  input  logic signed [scrc_pkg::COORD_W-1:0] in_clip_min_y,
  input  logic signed [scrc_pkg::COORD_W-1:0] in_clip_max_x,
  input  logic signed [scrc_pkg::COORD_W-1:0] in_clip_max_y,
  output logic                              push,
  output scrc_pkg::cmd_t                    push_cmd,
  input  logic                              q_full,
  output logic                              front_vld
);
  import scrc_pkg::*;

  logic vld_r, vld_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic load;

  // Take a new item whenever the holding register is free or drains
  assign push     = vld_r && !q_full;
  assign in_stall = vld_r && q_full;
  assign load     = in_valid && !in_stall;

  // Classify and scale the incoming rectangle
  always_comb begin
    cmd_nxt.frame_start = in_frame_start;
    cmd_nxt.skip        = in_is_callback || in_no_elements;
    cmd_nxt.mnx         = scale_coord(in_clip_min_x, cfg.offset_x, cfg.scale_x);
    cmd_nxt.mny         = scale_coord(in_clip_min_y, cfg.offset_y, cfg.scale_y);
    cmd_nxt.mxx         = scale_coord(in_clip_max_x, cfg.offset_x, cfg.scale_x);
    cmd_nxt.mxy         = scale_coord(in_clip_max_y, cfg.offset_y, cfg.scale_y);
  end

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign push_cmd  = cmd_r;
  assign front_vld = vld_r;

endmodule

/* hdl/scrc_queue.sv */
module scrc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  scrc_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output scrc_pkg::cmd_t    pop_cmd,
  output scrc_pkg::q_stat_t stat
);
  import scrc_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign pop_cmd    = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

/* hdl/scrc_back.sv */
module scrc_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  scrc_pkg::cfg_t                  cfg,
  input  logic                            q_empty,
  input  scrc_pkg::cmd_t                  pop_cmd,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_skipped,
  output logic [scrc_pkg::DIM_BITS-1:0]   out_rect_x,
  output logic [scrc_pkg::DIM_BITS-1:0]   out_rect_y,
  output logic [scrc_pkg::DIM_BITS-1:0]   out_rect_w,
  output logic [scrc_pkg::DIM_BITS-1:0]   out_rect_h,
  output logic                            out_degenerate,
  output logic                            out_exceeds,
  output logic [scrc_pkg::BADCNT_W-1:0]   out_bad_count
);
  import scrc_pkg::*;

  typedef struct packed {
    logic                frame_start;
    logic                skipped;
    logic [DIM_BITS-1:0] x;
    logic [DIM_BITS-1:0] y;
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;
  } span_t;

  span_t s1_r, s1_nxt;
  logic  s1_vld_r, s1_vld_nxt;
  logic  ov_r, ov_nxt;
  logic  adv_out, load_s1;

  logic signed [PROD_W-1:0] mnx_c, mny_c, mxx_c, mxy_c, fbx, fby;
  logic [FIX_W-1:0]         span_x, span_y;

  logic [DIM_BITS:0]     sum_x, sum_y;
  logic                  deg, exc, bad;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_base;

  logic                skip_r;
  logic [DIM_BITS-1:0] x_r, y_r, w_r, h_r;
  logic                deg_r, exc_r;

  assign adv_out = !ov_r || !out_stall;
  assign load_s1 = !s1_vld_r || adv_out;
  assign pop     = !q_empty && load_s1;

  // Clamp to the framebuffer, drop empty rectangles, truncate to pixels
  always_comb begin
    fbx = {{(PROD_W - FIX_W){1'b0}}, cfg.fb_width, {FRAC_BITS{1'b0}}};
    fby = {{(PROD_W - FIX_W){1'b0}}, cfg.fb_height, {FRAC_BITS{1'b0}}};
    mnx_c = pop_cmd.mnx[PROD_W-1] ? '0 : pop_cmd.mnx;
    mny_c = pop_cmd.mny[PROD_W-1] ? '0 : pop_cmd.mny;
    mxx_c = (pop_cmd.mxx > fbx) ? fbx : pop_cmd.mxx;
    mxy_c = (pop_cmd.mxy > fby) ? fby : pop_cmd.mxy;
    span_x = mxx_c[FIX_W-1:0] - mnx_c[FIX_W-1:0];
    span_y = mxy_c[FIX_W-1:0] - mny_c[FIX_W-1:0];
    s1_nxt.frame_start = pop_cmd.frame_start;
    s1_nxt.skipped     = pop_cmd.skip || (mxx_c <= mnx_c) || (mxy_c <= mny_c);
    s1_nxt.x           = mnx_c[FIX_W-1:FRAC_BITS];
    s1_nxt.y           = mny_c[FIX_W-1:FRAC_BITS];
    s1_nxt.w           = span_x[FIX_W-1:FRAC_BITS];
    s1_nxt.h           = span_y[FIX_W-1:FRAC_BITS];
  end

  // Flag the rectangle and update the per-frame counter
  always_comb begin
    sum_x    = {1'b0, s1_r.x} + {1'b0, s1_r.w};
    sum_y    = {1'b0, s1_r.y} + {1'b0, s1_r.h};
    deg      = (s1_r.w == '0) || (s1_r.h == '0);
    exc      = (sum_x > {1'b0, cfg.att_width}) || (sum_y > {1'b0, cfg.att_height}) ||
               (s1_r.x >= cfg.att_width) || (s1_r.y >= cfg.att_height);
    bad      = !s1_r.skipped && (deg || exc);
    cnt_base = s1_r.frame_start ? '0 : cnt_r;
    cnt_nxt  = (bad && (cnt_base != '1)) ? cnt_base + 1'b1 : cnt_base;
  end

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    ov_nxt     = ov_r;
    if (load_s1) begin
      s1_vld_nxt = !q_empty;
    end
    if (adv_out) begin
      ov_nxt = s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      ov_r     <= 1'b0;
      cnt_r    <= '0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      ov_r     <= ov_nxt;
      if (s1_vld_r && adv_out) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Hold stage payloads while the next stage is busy
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_r <= s1_nxt;
    end
    if (s1_vld_r && adv_out) begin
      skip_r <= s1_r.skipped;
      x_r    <= s1_r.skipped ? '0 : s1_r.x;
      y_r    <= s1_r.skipped ? '0 : s1_r.y;
      w_r    <= s1_r.skipped ? '0 : s1_r.w;
      h_r    <= s1_r.skipped ? '0 : s1_r.h;
      deg_r  <= !s1_r.skipped && deg;
      exc_r  <= !s1_r.skipped && exc;
    end
  end

  assign out_valid      = ov_r;
  assign out_skipped    = skip_r;
  assign out_rect_x     = x_r;
  assign out_rect_y     = y_r;
  assign out_rect_w     = w_r;
  assign out_rect_h     = h_r;
  assign out_degenerate = deg_r;
  assign out_exceeds    = exc_r;
  assign out_bad_count  = BADCNT_W'(cnt_r);

endmodule

/* verif/tb_scissor_rect_checker_unit.sv */
module tb_scissor_rect_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import scrc_pkg::*;

  typedef struct packed {
    logic                      frame_start;
    logic                      is_callback;
    logic                      no_elements;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
  } draw_cmd_t;

  typedef struct packed {
    logic                skipped;
    logic [DIM_BITS-1:0] x;
    logic [DIM_BITS-1:0] y;
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;
    logic                degenerate;
    logic                exceeds;
    logic [BADCNT_W-1:0] bad_count;
  } scissor_t;

  typedef struct {
    int        cfg_sel;
    draw_cmd_t cmd;
    bit        typed;
    scissor_t  want;
  } stim_row_t;

  // Named register sets for the directed part
  localparam int NO_CFG         = -1;
  localparam int CFG_PLAIN      = 0;
  localparam int CFG_SCALED     = 1;
  localparam int CFG_FAR_LOW    = 2;
  localparam int CFG_FAR_HIGH   = 3;
  localparam int CFG_ZERO_SCALE = 4;

  localparam int SETTLE_CYCLES  = 8;
  localparam int FRAME_ITEMS    = 32;
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_ITEMS    = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_frame_start = 1'b0;
  logic                      in_is_callback = 1'b0;
  logic                      in_no_elements = 1'b0;
  logic signed [COORD_W-1:0] in_clip_min_x = '0;
  logic signed [COORD_W-1:0] in_clip_min_y = '0;
  logic signed [COORD_W-1:0] in_clip_max_x = '0;
  logic signed [COORD_W-1:0] in_clip_max_y = '0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_skipped;
  logic [DIM_BITS-1:0] out_rect_x;
  logic [DIM_BITS-1:0] out_rect_y;
  logic [DIM_BITS-1:0] out_rect_w;
  logic [DIM_BITS-1:0] out_rect_h;
  logic                out_degenerate;
  logic                out_exceeds;
  logic [BADCNT_W-1:0] out_bad_count;

  // Predictor state: register copy and per-frame bad tally
  cfg_t                  shadow;
  logic [COUNT_BITS-1:0] bad_tally = '0;
  scissor_t              rect_expect_q[$];

  bit quiet = 1'b0;
  int errors = 0;
  int results_seen = 0;
  int skipped_seen = 0;
  int degenerate_seen = 0;
  int exceeds_seen = 0;
  int tally_peak = 0;
  int cfg_loads = 0;

  cfg_t      cfg_table[5];
  stim_row_t directed_rows[$];

  scissor_rect_checker_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_frame_start (in_frame_start),
    .in_is_callback (in_is_callback),
    .in_no_elements (in_no_elements),
    .in_clip_min_x  (in_clip_min_x),
    .in_clip_min_y  (in_clip_min_y),
    .in_clip_max_x  (in_clip_max_x),
    .in_clip_max_y  (in_clip_max_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_skipped    (out_skipped),
    .out_rect_x     (out_rect_x),
    .out_rect_y     (out_rect_y),
    .out_rect_w     (out_rect_w),
    .out_rect_h     (out_rect_h),
    .out_degenerate (out_degenerate),
    .out_exceeds    (out_exceeds),
    .out_bad_count  (out_bad_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic cfg_t mk_cfg(int ox, int oy, int sx, int sy,
                                  int fw, int fh, int aw, int ah);
    cfg_t k;
    k.offset_x   = COORD_W'(ox);
    k.offset_y   = COORD_W'(oy);
    k.scale_x    = SCALE_W'(sx);
    k.scale_y    = SCALE_W'(sy);
    k.fb_width   = DIM_BITS'(fw);
    k.fb_height  = DIM_BITS'(fh);
    k.att_width  = DIM_BITS'(aw);
    k.att_height = DIM_BITS'(ah);
    return k;
  endfunction

  function automatic draw_cmd_t mk_cmd(bit fs, bit cb, bit ne,
                                       int ax, int ay, int bx, int by);
    draw_cmd_t c;
    c.frame_start = fs;
    c.is_callback = cb;
    c.no_elements = ne;
    c.min_x = COORD_W'(ax);
    c.min_y = COORD_W'(ay);
    c.max_x = COORD_W'(bx);
    c.max_y = COORD_W'(by);
    return c;
  endfunction

  function automatic scissor_t mk_rect(bit skip, int x, int y, int w, int h,
                                       bit dg, bit ex, int cnt);
    scissor_t r;
    r.skipped    = skip;
    r.x          = DIM_BITS'(x);
    r.y          = DIM_BITS'(y);
    r.w          = DIM_BITS'(w);
    r.h          = DIM_BITS'(h);
    r.degenerate = dg;
    r.exceeds    = ex;
    r.bad_count  = BADCNT_W'(cnt);
    return r;
  endfunction

  // Scale, clamp and truncate one command; advance the bad tally
  function automatic scissor_t scissor_from_clip(draw_cmd_t c);
    scissor_t r;
    longint   mnx, mny, mxx, mxy, fbx, fby;
    longint   x, y, w, h, aw, ah;
    bit       degen, over;
    if (c.frame_start) bad_tally = '0;
    r = '0;
    r.skipped = 1'b1;
    r.bad_count = bad_tally;
    if (c.is_callback || c.no_elements) return r;

    mnx = (longint'(c.min_x) - longint'($signed(shadow.offset_x))) * longint'(shadow.scale_x);
    mny = (longint'(c.min_y) - longint'($signed(shadow.offset_y))) * longint'(shadow.scale_y);
    mxx = (longint'(c.max_x) - longint'($signed(shadow.offset_x))) * longint'(shadow.scale_x);
    mxy = (longint'(c.max_y) - longint'($signed(shadow.offset_y))) * longint'(shadow.scale_y);

    // Clamp to the framebuffer in 2^-16 pixel units
    fbx = longint'(shadow.fb_width) * 65536;
    fby = longint'(shadow.fb_height) * 65536;
    if (mnx < 0) mnx = 0;
    if (mny < 0) mny = 0;
    if (mxx > fbx) mxx = fbx;
    if (mxy > fby) mxy = fby;
    if (mxx <= mnx || mxy <= mny) return r;

    x = mnx >>> 16;
    y = mny >>> 16;
    w = (mxx - mnx) >>> 16;
    h = (mxy - mny) >>> 16;
    aw = longint'(shadow.att_width);
    ah = longint'(shadow.att_height);
    degen = (w == 0) || (h == 0);
    over = (x + w > aw) || (y + h > ah) || (x >= aw) || (y >= ah);
    if ((degen || over) && bad_tally != '1) bad_tally = bad_tally + 1'b1;

    r.skipped    = 1'b0;
    r.x          = DIM_BITS'(x);
    r.y          = DIM_BITS'(y);
    r.w          = DIM_BITS'(w);
    r.h          = DIM_BITS'(h);
    r.degenerate = degen;
    r.exceeds    = over;
    r.bad_count  = bad_tally;
    return r;
  endfunction

  // Mostly a typical value, now and then an extreme or a full-range draw
  function automatic int pick_field(int typ_lo, int typ_hi, int ext_lo, int ext_hi);
    int r;
    r = $urandom_range(0, 11);
    unique case (r)
      0: return ext_lo;
      1: return ext_hi;
      2: return ext_lo + int'($urandom_range(0, ext_hi - ext_lo));
      default: return typ_lo + int'($urandom_range(0, typ_hi - typ_lo));
    endcase
  endfunction

  function automatic cfg_t draw_cfg();
    cfg_t k;
    int   fw, fh;
    fw = pick_field(16, 1024, 0, 16383);
    fh = pick_field(16, 1024, 0, 16383);
    k.offset_x   = COORD_W'(pick_field(-4096, 4096, -524288, 524287));
    k.offset_y   = COORD_W'(pick_field(-4096, 4096, -524288, 524287));
    k.scale_x    = SCALE_W'(pick_field(2048, 8192, 0, 65535));
    k.scale_y    = SCALE_W'(pick_field(2048, 8192, 0, 65535));
    k.fb_width   = DIM_BITS'(fw);
    k.fb_height  = DIM_BITS'(fh);
    k.att_width  = DIM_BITS'(pick_field((fw > 32) ? fw - 32 : 0,
                                        (fw < 16351) ? fw + 32 : 16383, 0, 16383));
    k.att_height = DIM_BITS'(pick_field((fh > 32) ? fh - 32 : 0,
                                        (fh < 16351) ? fh + 32 : 16383, 0, 16383));
    return k;
  endfunction

  // Span of a rectangle edge pair: sometimes inverted or sub-pixel
  function automatic int draw_span();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -int'($urandom_range(1, 64));
    if (r < 3) return int'($urandom_range(0, 48));
    return int'($urandom_range(16, 12000));
  endfunction

  function automatic draw_cmd_t draw_cmd();
    draw_cmd_t c;
    int        kind, lo_x, lo_y;
    kind = $urandom_range(0, 99);
    c = '0;
    c.frame_start = ($urandom_range(0, 15) == 0);
    if (kind < 15) begin
      c.min_x = COORD_W'($urandom);
      c.min_y = COORD_W'($urandom);
      c.max_x = COORD_W'($urandom);
      c.max_y = COORD_W'($urandom);
    end else begin
      lo_x = int'($urandom_range(0, 32768)) - 8192;
      lo_y = int'($urandom_range(0, 32768)) - 8192;
      c.min_x = COORD_W'(lo_x);
      c.min_y = COORD_W'(lo_y);
      c.max_x = COORD_W'(lo_x + draw_span());
      c.max_y = COORD_W'(lo_y + draw_span());
    end
    if (kind >= 90) begin
      c.is_callback = 1'($urandom_range(0, 1));
      c.no_elements = !c.is_callback || ($urandom_range(0, 1) != 0);
    end
    return c;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s mismatch, got %0d want %0d", $time, field, got, want);
    errors++;
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (rect_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers, then mirror them in the predictor
  task automatic load_cfg(cfg_t k);
    logic [CFG_DATA_W-1:0] reg_val[8];
    reg_val[REG_OFFSET_X]   = k.offset_x;
    reg_val[REG_OFFSET_Y]   = k.offset_y;
    reg_val[REG_SCALE_X]    = CFG_DATA_W'(k.scale_x);
    reg_val[REG_SCALE_Y]    = CFG_DATA_W'(k.scale_y);
    reg_val[REG_FB_WIDTH]   = CFG_DATA_W'(k.fb_width);
    reg_val[REG_FB_HEIGHT]  = CFG_DATA_W'(k.fb_height);
    reg_val[REG_ATT_WIDTH]  = CFG_DATA_W'(k.att_width);
    reg_val[REG_ATT_HEIGHT] = CFG_DATA_W'(k.att_height);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= reg_val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    shadow = k;
    cfg_loads++;
  endtask

  // Offer one command after a random gap; predict once it is taken
  task automatic issue_cmd(draw_cmd_t c, bit typed, scissor_t want);
    int       gap;
    scissor_t pred;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_frame_start <= c.frame_start;
    in_is_callback <= c.is_callback;
    in_no_elements <= c.no_elements;
    in_clip_min_x  <= c.min_x;
    in_clip_min_y  <= c.min_y;
    in_clip_max_x  <= c.max_x;
    in_clip_max_y  <= c.max_y;
    do @(posedge clk); while (in_stall);
    pred = scissor_from_clip(c);
    rect_expect_q.push_back(typed ? want : pred);
  endtask

  // Result side: random stall per item, then compare with the oldest prediction
  initial begin
    int       hold;
    scissor_t got, want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.skipped    = out_skipped;
      got.x          = out_rect_x;
      got.y          = out_rect_y;
      got.w          = out_rect_w;
      got.h          = out_rect_h;
      got.degenerate = out_degenerate;
      got.exceeds    = out_exceeds;
      got.bad_count  = out_bad_count;
      results_seen++;
      if (rect_expect_q.size() == 0) begin
        flag_mismatch("unexpected result", 32'(got.bad_count), 32'd0);
      end else begin
        want = rect_expect_q.pop_front();
        if (got.skipped !== want.skipped)
          flag_mismatch("skipped", 32'(got.skipped), 32'(want.skipped));
        if (got.x !== want.x) flag_mismatch("rect_x", 32'(got.x), 32'(want.x));
        if (got.y !== want.y) flag_mismatch("rect_y", 32'(got.y), 32'(want.y));
        if (got.w !== want.w) flag_mismatch("rect_w", 32'(got.w), 32'(want.w));
        if (got.h !== want.h) flag_mismatch("rect_h", 32'(got.h), 32'(want.h));
        if (got.degenerate !== want.degenerate)
          flag_mismatch("degenerate", 32'(got.degenerate), 32'(want.degenerate));
        if (got.exceeds !== want.exceeds)
          flag_mismatch("exceeds", 32'(got.exceeds), 32'(want.exceeds));
        if (got.bad_count !== want.bad_count)
          flag_mismatch("bad_count", 32'(got.bad_count), 32'(want.bad_count));
        if (want.skipped) skipped_seen++;
        if (want.degenerate) degenerate_seen++;
        if (want.exceeds) exceeds_seen++;
        if (int'(want.bad_count) > tally_peak) tally_peak = int'(want.bad_count);
      end
    end
  end

  // Hang guard
  initial begin
    #10_000_000;
    $display("FAIL scissor_rect_checker_unit");
    $finish;
  end

  initial begin
    draw_cmd_t dot;
    shadow = mk_cfg(0, 0, int'(SCALE_ONE), int'(SCALE_ONE), 0, 0, 0, 0);

    cfg_table[CFG_PLAIN]      = mk_cfg(0, 0, 4096, 4096, 640, 480, 640, 480);
    cfg_table[CFG_SCALED]     = mk_cfg(160, -80, 6144, 2048, 800, 600, 320, 200);
    cfg_table[CFG_FAR_LOW]    = mk_cfg(-524288, -524288, 1, 4096, 16383, 16383, 0, 0);
    cfg_table[CFG_FAR_HIGH]   = mk_cfg(524287, 0, 65535, 65535, 16383, 16383, 16383, 16383);
    cfg_table[CFG_ZERO_SCALE] = mk_cfg(0, 0, 0, 0, 640, 480, 640, 480);

    // Reset values: empty framebuffer clips everything away
    directed_rows.push_back('{NO_CFG, mk_cmd(1, 0, 0, 0, 0, 160, 160), 1,
                              mk_rect(1, 0, 0, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 1, 0, 0, 0, 160, 160), 1,
                              mk_rect(1, 0, 0, 0, 0, 0, 0, 0)});
    // Unit scale, 640x480: flags, plain, full, clamped, empty and flagged rectangles
    directed_rows.push_back('{CFG_PLAIN, mk_cmd(0, 0, 1, 0, 0, 160, 160), 1,
                              mk_rect(1, 0, 0, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 0, 0, 160, 320, 1760, 1120), 1,
                              mk_rect(0, 10, 20, 100, 50, 0, 0, 0)});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 0, 0, 0, 0, 10240, 7680), 1,
                              mk_rect(0, 0, 0, 640, 480, 0, 0, 0)});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 0, 0, -524288, -524288, 524287, 524287), 1,
                              mk_rect(0, 0, 0, 640, 480, 0, 0, 0)});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 0, 0, 320, 320, 320, 640), 1,
                              mk_rect(1, 0, 0, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 0, 0, 640, 640, 320, 960), 1,
                              mk_rect(1, 0, 0, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 0, 0, 11200, 0, 12000, 160), 1,
                              mk_rect(1, 0, 0, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 0, 0, 0, 0, 8, 160), 1,
                              mk_rect(0, 0, 0, 0, 10, 1, 0, 1)});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 0, 0, 24, 24, 31, 31), 1,
                              mk_rect(0, 1, 1, 0, 0, 1, 0, 2)});
    directed_rows.push_back('{NO_CFG, mk_cmd(1, 0, 0, 0, 0, 16, 16), 1,
                              mk_rect(0, 0, 0, 1, 1, 0, 0, 0)});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 1, 1, -524288, -524288, 524287, 524287), 1,
                              mk_rect(1, 0, 0, 0, 0, 0, 0, 0)});
    // Offset and uneven scale, attachment smaller than the framebuffer
    directed_rows.push_back('{CFG_SCALED, mk_cmd(0, 0, 0, 0, 0, 4000, 4000), 0, '0});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 0, 0, 1000, -2000, 9000, 3000), 0, '0});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 0, 0, -524288, 0, 524287, 524287), 0, '0});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 0, 0, 16000, 8000, 30000, 90000), 0, '0});
    directed_rows.push_back('{NO_CFG, mk_cmd(1, 0, 0, 160, -80, 200, 100), 0, '0});
    // Register extremes
    directed_rows.push_back('{CFG_FAR_LOW, mk_cmd(0, 0, 0, -524288, -524288, 524287, 524287),
                              0, '0});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 0, 0, 0, 0, 100, 100), 0, '0});
    directed_rows.push_back('{CFG_FAR_HIGH, mk_cmd(0, 0, 0, -524288, 0, 524287, 524287),
                              0, '0});
    directed_rows.push_back('{NO_CFG, mk_cmd(0, 0, 0, 524287, -524288, -524288, 524287),
                              0, '0});
    // Zero scale collapses every rectangle
    directed_rows.push_back('{CFG_ZERO_SCALE, mk_cmd(1, 0, 0, 0, 0, 160, 160), 1,
                              mk_rect(1, 0, 0, 0, 0, 0, 0, 0)});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_sel != NO_CFG) begin
        settle();
        load_cfg(cfg_table[directed_rows[i].cfg_sel]);
      end
      issue_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases, each under a fresh register set; the first runs without gaps
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      load_cfg(draw_cfg());
      quiet = (p == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) settle();
        issue_cmd(draw_cmd(), 1'b0, '0);
      end
    end

    // One long frame of back-to-back degenerate rectangles, then a callback and a new frame
    settle();
    load_cfg(cfg_table[CFG_PLAIN]);
    quiet = 1'b1;
    dot = mk_cmd(1, 0, 0, 0, 0, 8, 160);
    for (int n = 0; n < FRAME_ITEMS; n++) begin
      issue_cmd(dot, 1'b0, '0);
      dot.frame_start = 1'b0;
    end
    quiet = 1'b0;
    issue_cmd(mk_cmd(0, 1, 0, 0, 0, 8, 160), 1'b0, '0);
    issue_cmd(mk_cmd(1, 0, 0, 0, 0, 8, 160), 1'b0, '0);

    settle();
    $display("%0d scissor results compared: %0d skipped, %0d degenerate, %0d past attachment",
             results_seen, skipped_seen, degenerate_seen, exceeds_seen);
    $display("%0d register sets loaded, bad counter reached %0d", cfg_loads, tally_peak);
    if (errors == 0) begin
      $display("PASS scissor_rect_checker_unit");
    end else begin
      $display("FAIL scissor_rect_checker_unit");
    end
    $finish;
  end

endmodule

/* scissor_rect_checker_unit.f */
+incdir+hdl
hdl/scrc_pkg.sv
hdl/scrc_front.sv
hdl/scrc_queue.sv
hdl/scrc_back.sv
hdl/scissor_rect_checker_unit.sv
verif/tb_scissor_rect_checker_unit.sv
